/* sv/tal_pkg.sv */
`timescale 1ns / 1ps
package tal_pkg;

   localparam int COEFF_WIDTH = 12;
   localparam int FRAC_BITS   = 8;

   localparam int PROD_W   = 2 * COEFF_WIDTH;
   localparam int SUM_W    = 2 * COEFF_WIDTH + 1;
   localparam int MAG_W    = 2 * COEFF_WIDTH;
   localparam int NUM_W    = MAG_W + FRAC_BITS;
   localparam int PT_W     = 32;
   localparam int DIFF_W   = PT_W + 1;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int ROOT_W   = DIFF_W;
   localparam int SIDE_W   = 33;
   localparam int CROSS_W  = SQ_W + 1;
   localparam int AREA_W   = 57;

   localparam int FRONT_LAT = 2;
   localparam int DIV_LAT   = NUM_W + 2;
   localparam int GEO_LAT   = 4;
   localparam int SQRT_LAT  = ROOT_W;
   localparam int CORE_LAT  = FRONT_LAT + DIV_LAT + GEO_LAT + SQRT_LAT;

   typedef logic [1:0] status_type;

   localparam status_type ST_TRIANGLE = 2'd0;
   localparam status_type ST_PAR12    = 2'd1;
   localparam status_type ST_PAR23    = 2'd2;
   localparam status_type ST_PAR13    = 2'd3;

   typedef struct packed {
      logic signed [COEFF_WIDTH-1:0] line1_a;
      logic signed [COEFF_WIDTH-1:0] line1_b;
      logic signed [COEFF_WIDTH-1:0] line1_c;
      logic signed [COEFF_WIDTH-1:0] line2_a;
      logic signed [COEFF_WIDTH-1:0] line2_b;
      logic signed [COEFF_WIDTH-1:0] line2_c;
      logic signed [COEFF_WIDTH-1:0] line3_a;
      logic signed [COEFF_WIDTH-1:0] line3_b;
      logic signed [COEFF_WIDTH-1:0] line3_c;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [PT_W-1:0]   point12_x;
      logic signed [PT_W-1:0]   point12_y;
      logic signed [PT_W-1:0]   point23_x;
      logic signed [PT_W-1:0]   point23_y;
      logic signed [PT_W-1:0]   point13_x;
      logic signed [PT_W-1:0]   point13_y;
      logic [SIDE_W-1:0]        side_first;
      logic [SIDE_W-1:0]        side_second;
      logic [SIDE_W-1:0]        side_third;
      logic [AREA_W-1:0]        area;
   } rsp_type;

   typedef struct packed {
      status_type                 status;
      logic [2:0][SUM_W-1:0]      det;
      logic [2:0][SUM_W-1:0]      nx;
      logic [2:0][SUM_W-1:0]      ny;
   } front_type;

endpackage

/* sv/tal_front.sv */
`timescale 1ns / 1ps
module tal_front import tal_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  req_type   req,
   output front_type front
);

   localparam int PI [3] = '{0, 1, 0};
   localparam int PJ [3] = '{1, 2, 2};

   logic signed [COEFF_WIDTH-1:0] la [3];
   logic signed [COEFF_WIDTH-1:0] lb [3];
   logic signed [COEFF_WIDTH-1:0] lc [3];
   logic signed [PROD_W-1:0]      pr_ff [3][6];
   front_type                     front_ff;
   front_type                     front_in;

   assign la[0] = req.line1_a;
   assign lb[0] = req.line1_b;
   assign lc[0] = req.line1_c;
   assign la[1] = req.line2_a;
   assign lb[1] = req.line2_b;
   assign lc[1] = req.line2_c;
   assign la[2] = req.line3_a;
   assign lb[2] = req.line3_b;
   assign lc[2] = req.line3_c;

   for (genvar p = 0; p < 3; p++) begin : g_pair
      always_ff @(posedge clock) begin
         if (en) begin
            pr_ff[p][0] <= PROD_W'(la[PI[p]] * lb[PJ[p]]);
            pr_ff[p][1] <= PROD_W'(la[PJ[p]] * lb[PI[p]]);
            pr_ff[p][2] <= PROD_W'(lc[PI[p]] * lb[PJ[p]]);
            pr_ff[p][3] <= PROD_W'(lc[PJ[p]] * lb[PI[p]]);
            pr_ff[p][4] <= PROD_W'(la[PI[p]] * lc[PJ[p]]);
            pr_ff[p][5] <= PROD_W'(la[PJ[p]] * lc[PI[p]]);
         end
      end
   end

   always_comb begin
      front_in = '0;
      for (int p = 0; p < 3; p++) begin
         front_in.det[p] = SUM_W'(pr_ff[p][0]) - SUM_W'(pr_ff[p][1]);
         front_in.nx[p]  = SUM_W'(pr_ff[p][2]) - SUM_W'(pr_ff[p][3]);
         front_in.ny[p]  = SUM_W'(pr_ff[p][4]) - SUM_W'(pr_ff[p][5]);
      end
      if (front_in.det[0] == '0) begin
         front_in.status = ST_PAR12;
      end else if (front_in.det[1] == '0) begin
         front_in.status = ST_PAR23;
      end else if (front_in.det[2] == '0) begin
         front_in.status = ST_PAR13;
      end else begin
         front_in.status = ST_TRIANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

/* sv/tal_div.sv */
`timescale 1ns / 1ps
module tal_div import tal_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [SUM_W-1:0] num,
   input  logic signed [SUM_W-1:0] den,
   output logic signed [PT_W-1:0]  quo
);

   localparam int QX_W = ((NUM_W > PT_W) ? NUM_W : PT_W) + 1;
   localparam logic [QX_W-1:0] POS_LIM = QX_W'({(PT_W-1){1'b1}});
   localparam logic [QX_W-1:0] NEG_LIM = QX_W'(1) << (PT_W - 1);

   logic [NUM_W-1:0]       n_ff   [0:NUM_W];
   logic [MAG_W-1:0]       r_ff   [0:NUM_W];
   logic [MAG_W-1:0]       d_ff   [0:NUM_W];
   logic [NUM_W-1:0]       q_ff   [0:NUM_W];
   logic                   neg_ff [0:NUM_W];
   logic [SUM_W-1:0]       nabs;
   logic [SUM_W-1:0]       dabs;
   logic [QX_W-1:0]        qx;
   logic signed [PT_W-1:0] quo_ff;
   logic signed [PT_W-1:0] quo_in;

   assign nabs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
   assign dabs = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]   <= NUM_W'(nabs[MAG_W-1:0]) << FRAC_BITS;
         r_ff[0]   <= '0;
         d_ff[0]   <= dabs[MAG_W-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= num[SUM_W-1] ^ den[SUM_W-1];
      end
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_step
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;

      assign trial = {r_ff[k], n_ff[k][NUM_W-1]};
      assign diff  = trial - {1'b0, d_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k+1]   <= n_ff[k] << 1;
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            if (trial >= {1'b0, d_ff[k]}) begin
               r_ff[k+1] <= diff[MAG_W-1:0];
               q_ff[k+1] <= {q_ff[k][NUM_W-2:0], 1'b1};
            end else begin
               r_ff[k+1] <= trial[MAG_W-1:0];
               q_ff[k+1] <= {q_ff[k][NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   assign qx = QX_W'(q_ff[NUM_W]);

   always_comb begin
      if (!neg_ff[NUM_W]) begin
         quo_in = (qx > POS_LIM) ? {1'b0, {(PT_W-1){1'b1}}} : PT_W'(qx);
      end else begin
         quo_in = (qx > NEG_LIM) ? {1'b1, {(PT_W-1){1'b0}}} : PT_W'(-qx);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

/* sv/tal_sqrt.sv */
`timescale 1ns / 1ps
module tal_sqrt import tal_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [SQ_W-1:0]   rad,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_W-1:0]   rem_ff  [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W-1];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_step
      localparam int B = ROOT_W - 1 - k;
      logic [SQ_W-1:0]   prev_rem;
      logic [ROOT_W-1:0] prev_root;
      logic [SQ_W:0]     trial;

      if (k == 0) begin : g_first
         assign prev_rem  = rad;
         assign prev_root = '0;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
      end

      assign trial = ((SQ_W+1)'(prev_root) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if (trial <= {1'b0, prev_rem}) begin
               rem_ff[k]  <= prev_rem - trial[SQ_W-1:0];
               root_ff[k] <= prev_root | (ROOT_W'(1) << B);
            end else begin
               rem_ff[k]  <= prev_rem;
               root_ff[k] <= prev_root;
            end
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

/* sv/triangle_area_from_three_lines.sv */
`timescale 1ns / 1ps
// A req transfer reaches the rsp result through the front products, the 32-step restoring
// dividers, the geometry registers and the 33-step square root pipelines.
// Throughput is one line triple per cycle; a stalled rsp freezes the whole pipeline.
// Reset is synchronous and clears only the valid bits; data registers are not reset.
module triangle_area_from_three_lines import tal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                     en;
   front_type                front;
   logic signed [PT_W-1:0]   qx [3];
   logic signed [PT_W-1:0]   qy [3];
   logic                     v_line_ff [0:CORE_LAT-1];
   status_type               s_line_ff [0:CORE_LAT-FRONT_LAT-1];
   logic signed [DIFF_W-1:0] gdx_ff [3];
   logic signed [DIFF_W-1:0] gdy_ff [3];
   logic signed [DIFF_W-1:0] ce_ff [2];
   logic signed [DIFF_W-1:0] cf_ff [2];
   logic [DIFF_W-1:0]        adx_ff [3];
   logic [DIFF_W-1:0]        ady_ff [3];
   logic signed [DIFF_W-1:0] ce2_ff [2];
   logic signed [DIFF_W-1:0] cf2_ff [2];
   logic [SQ_W-1:0]          sqx_ff [3];
   logic [SQ_W-1:0]          sqy_ff [3];
   logic signed [SQ_W-1:0]   cp_ff [2];
   logic [SQ_W-1:0]          rad_ff [3];
   logic signed [CROSS_W-1:0] cross_ff;
   logic [CROSS_W-1:0]       cross_abs;
   logic [AREA_W-1:0]        area_line_ff [0:SQRT_LAT-1];
   logic signed [PT_W-1:0]   px_line_ff [0:GEO_LAT+SQRT_LAT-1][3];
   logic signed [PT_W-1:0]   py_line_ff [0:GEO_LAT+SQRT_LAT-1][3];
   logic [ROOT_W-1:0]        root [3];
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   tal_front u_front (
      .clock (clock),
      .en    (en),
      .req   (req_data),
      .front (front)
   );

   for (genvar p = 0; p < 3; p++) begin : g_meet
      tal_div u_div_x (
         .clock (clock),
         .en    (en),
         .num   ($signed(front.nx[p])),
         .den   ($signed(front.det[p])),
         .quo   (qx[p])
      );
      tal_div u_div_y (
         .clock (clock),
         .en    (en),
         .num   ($signed(front.ny[p])),
         .den   ($signed(front.det[p])),
         .quo   (qy[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORE_LAT; i++) begin
            v_line_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_line_ff[0] <= req_valid;
         for (int i = 1; i < CORE_LAT; i++) begin
            v_line_ff[i] <= v_line_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_line_ff[0] <= front.status;
         for (int i = 1; i < CORE_LAT - FRONT_LAT; i++) begin
            s_line_ff[i] <= s_line_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gdx_ff[0] <= DIFF_W'(qx[0]) - DIFF_W'(qx[1]);
         gdy_ff[0] <= DIFF_W'(qy[0]) - DIFF_W'(qy[1]);
         gdx_ff[1] <= DIFF_W'(qx[1]) - DIFF_W'(qx[2]);
         gdy_ff[1] <= DIFF_W'(qy[1]) - DIFF_W'(qy[2]);
         gdx_ff[2] <= DIFF_W'(qx[0]) - DIFF_W'(qx[2]);
         gdy_ff[2] <= DIFF_W'(qy[0]) - DIFF_W'(qy[2]);
         ce_ff[0]  <= DIFF_W'(qx[1]) - DIFF_W'(qx[0]);
         cf_ff[0]  <= DIFF_W'(qy[2]) - DIFF_W'(qy[0]);
         ce_ff[1]  <= DIFF_W'(qx[2]) - DIFF_W'(qx[0]);
         cf_ff[1]  <= DIFF_W'(qy[1]) - DIFF_W'(qy[0]);

         for (int i = 0; i < 3; i++) begin
            adx_ff[i] <= gdx_ff[i][DIFF_W-1] ? DIFF_W'(-gdx_ff[i]) : DIFF_W'(gdx_ff[i]);
            ady_ff[i] <= gdy_ff[i][DIFF_W-1] ? DIFF_W'(-gdy_ff[i]) : DIFF_W'(gdy_ff[i]);
         end
         for (int i = 0; i < 2; i++) begin
            ce2_ff[i] <= ce_ff[i];
            cf2_ff[i] <= cf_ff[i];
         end

         for (int i = 0; i < 3; i++) begin
            sqx_ff[i] <= SQ_W'(adx_ff[i]) * SQ_W'(adx_ff[i]);
            sqy_ff[i] <= SQ_W'(ady_ff[i]) * SQ_W'(ady_ff[i]);
         end
         for (int i = 0; i < 2; i++) begin
            cp_ff[i] <= SQ_W'(ce2_ff[i]) * SQ_W'(cf2_ff[i]);
         end

         for (int i = 0; i < 3; i++) begin
            rad_ff[i] <= sqx_ff[i] + sqy_ff[i];
         end
         cross_ff <= CROSS_W'(cp_ff[0]) - CROSS_W'(cp_ff[1]);

         area_line_ff[0] <= cross_abs[FRAC_BITS+1 +: AREA_W];
         for (int i = 1; i < SQRT_LAT; i++) begin
            area_line_ff[i] <= area_line_ff[i-1];
         end

         for (int j = 0; j < 3; j++) begin
            px_line_ff[0][j] <= qx[j];
            py_line_ff[0][j] <= qy[j];
         end
         for (int i = 1; i < GEO_LAT + SQRT_LAT; i++) begin
            for (int j = 0; j < 3; j++) begin
               px_line_ff[i][j] <= px_line_ff[i-1][j];
               py_line_ff[i][j] <= py_line_ff[i-1][j];
            end
         end
      end
   end

   assign cross_abs = cross_ff[CROSS_W-1] ? CROSS_W'(-cross_ff) : CROSS_W'(cross_ff);

   for (genvar s = 0; s < 3; s++) begin : g_side
      tal_sqrt u_sqrt (
         .clock (clock),
         .en    (en),
         .rad   (rad_ff[s]),
         .root  (root[s])
      );
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.status = s_line_ff[CORE_LAT-FRONT_LAT-1];
      if (s_line_ff[CORE_LAT-FRONT_LAT-1] == ST_TRIANGLE) begin
         rsp_data_in.point12_x   = px_line_ff[GEO_LAT+SQRT_LAT-1][0];
         rsp_data_in.point12_y   = py_line_ff[GEO_LAT+SQRT_LAT-1][0];
         rsp_data_in.point23_x   = px_line_ff[GEO_LAT+SQRT_LAT-1][1];
         rsp_data_in.point23_y   = py_line_ff[GEO_LAT+SQRT_LAT-1][1];
         rsp_data_in.point13_x   = px_line_ff[GEO_LAT+SQRT_LAT-1][2];
         rsp_data_in.point13_y   = py_line_ff[GEO_LAT+SQRT_LAT-1][2];
         rsp_data_in.side_first  = SIDE_W'(root[0]);
         rsp_data_in.side_second = SIDE_W'(root[1]);
         rsp_data_in.side_third  = SIDE_W'(root[2]);
         rsp_data_in.area        = area_line_ff[SQRT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_line_ff[CORE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_TRIANGLE |->
         rsp_data.area == '0 && rsp_data.side_first == '0 && rsp_data.point12_x == '0)
      else $error("parallel result carries nonzero geometry");

   a_side_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_TRIANGLE |->
         ({1'b0, rsp_data.side_first} <=
          {1'b0, rsp_data.side_second} + {1'b0, rsp_data.side_third} + 1'b1))
      else $error("side lengths violate the triangle inequality");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the output register");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(v_line_ff[CORE_LAT-1]) && $stable(rsp_valid))
      else $error("pipeline advanced while the result was held");
`endif

endmodule

/* sim/triangle_area_from_three_lines_tb.sv */
`timescale 1ns / 1ps
module triangle_area_from_three_lines_tb;
   import tal_pkg::*;

   localparam int LATENCY = 74;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type triangle_queue[$];
   int      fail_count = 0;
   bit      quiet_tail = 1'b0;
   longint  cycle_count = 0;

   triangle_area_from_three_lines dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("triangle_area_from_three_lines_tb NOT OK");
         $finish;
      end
   end

   function automatic logic signed [31:0] meet_coord(longint num, longint det);
      longint q;
      q = (num * (64'sd1 <<< FRAC_BITS)) / det;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function automatic logic [32:0] side_length(longint x1, longint y1,
                                               longint x2, longint y2);
      logic [127:0] sq;
      logic [127:0] dx;
      logic [127:0] dy;
      logic [127:0] r;
      logic [127:0] t;
      dx = 128'((x1 > x2) ? x1 - x2 : x2 - x1);
      dy = 128'((y1 > y2) ? y1 - y2 : y2 - y1);
      sq = dx * dx + dy * dy;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (128'd1 << b);
         if (t * t <= sq) r = t;
      end
      return r[32:0];
   endfunction

   function automatic rsp_type triangle_of(req_type q);
      rsp_type o;
      longint a[3];
      longint b[3];
      longint c[3];
      longint px[3];
      longint py[3];
      logic signed [127:0] cross_prod;
      int i;
      int j;
      int pi[3];
      int pj[3];
      o = '0;
      a[0] = longint'(q.line1_a); b[0] = longint'(q.line1_b); c[0] = longint'(q.line1_c);
      a[1] = longint'(q.line2_a); b[1] = longint'(q.line2_b); c[1] = longint'(q.line2_c);
      a[2] = longint'(q.line3_a); b[2] = longint'(q.line3_b); c[2] = longint'(q.line3_c);
      if (a[0] * b[1] == a[1] * b[0]) o.status = ST_PAR12;
      else if (a[1] * b[2] == a[2] * b[1]) o.status = ST_PAR23;
      else if (a[0] * b[2] == a[2] * b[0]) o.status = ST_PAR13;
      else o.status = ST_TRIANGLE;
      if (o.status != ST_TRIANGLE) return o;
      pi = '{0, 1, 0};
      pj = '{1, 2, 2};
      for (int k = 0; k < 3; k++) begin
         i = pi[k];
         j = pj[k];
         px[k] = longint'(meet_coord(c[i] * b[j] - c[j] * b[i],
                                     a[i] * b[j] - a[j] * b[i]));
         py[k] = longint'(meet_coord(a[i] * c[j] - a[j] * c[i],
                                     a[i] * b[j] - a[j] * b[i]));
      end
      o.point12_x = 32'(px[0]); o.point12_y = 32'(py[0]);
      o.point23_x = 32'(px[1]); o.point23_y = 32'(py[1]);
      o.point13_x = 32'(px[2]); o.point13_y = 32'(py[2]);
      o.side_first  = side_length(px[0], py[0], px[1], py[1]);
      o.side_second = side_length(px[1], py[1], px[2], py[2]);
      o.side_third  = side_length(px[0], py[0], px[2], py[2]);
      cross_prod = 128'(signed'(px[1] - px[0])) * 128'(signed'(py[2] - py[0]))
                 - 128'(signed'(px[2] - px[0])) * 128'(signed'(py[1] - py[0]));
      if (cross_prod < 0) cross_prod = -cross_prod;
      cross_prod = cross_prod >> (FRAC_BITS + 1);
      o.area = cross_prod[56:0];
      return o;
   endfunction

   task automatic send_lines(req_type q);
      int gap;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         gap = int'($urandom_range(1, 18));
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      triangle_queue.push_back(triangle_of(q));
   endtask

   function automatic logic signed [11:0] rand_coeff();
      case ($urandom_range(0, 5))
         0: return 12'sh800;
         1: return 12'sh7ff;
         2: return 12'(signed'($urandom_range(0, 16)) - 8);
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic req_type rand_lines();
      req_type q;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(req_type)-1:0];
      if ($urandom_range(0, 3) == 0) begin
         q.line1_a = rand_coeff(); q.line1_b = rand_coeff(); q.line1_c = rand_coeff();
         q.line2_a = rand_coeff(); q.line2_b = rand_coeff(); q.line2_c = rand_coeff();
         q.line3_a = rand_coeff(); q.line3_b = rand_coeff(); q.line3_c = rand_coeff();
      end
      return q;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (triangle_queue.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            fail_count++;
         end else begin
            want = triangle_queue.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.point12_x !== want.point12_x) begin
               $error("point12_x exp %0d got %0d", want.point12_x, rsp_data.point12_x);
               fail_count++;
            end
            if (rsp_data.point12_y !== want.point12_y) begin
               $error("point12_y exp %0d got %0d", want.point12_y, rsp_data.point12_y);
               fail_count++;
            end
            if (rsp_data.point23_x !== want.point23_x) begin
               $error("point23_x exp %0d got %0d", want.point23_x, rsp_data.point23_x);
               fail_count++;
            end
            if (rsp_data.point23_y !== want.point23_y) begin
               $error("point23_y exp %0d got %0d", want.point23_y, rsp_data.point23_y);
               fail_count++;
            end
            if (rsp_data.point13_x !== want.point13_x) begin
               $error("point13_x exp %0d got %0d", want.point13_x, rsp_data.point13_x);
               fail_count++;
            end
            if (rsp_data.point13_y !== want.point13_y) begin
               $error("point13_y exp %0d got %0d", want.point13_y, rsp_data.point13_y);
               fail_count++;
            end
            if (rsp_data.side_first !== want.side_first) begin
               $error("side_first exp %0d got %0d", want.side_first, rsp_data.side_first);
               fail_count++;
            end
            if (rsp_data.side_second !== want.side_second) begin
               $error("side_second exp %0d got %0d", want.side_second,
                      rsp_data.side_second);
               fail_count++;
            end
            if (rsp_data.side_third !== want.side_third) begin
               $error("side_third exp %0d got %0d", want.side_third, rsp_data.side_third);
               fail_count++;
            end
            if (rsp_data.area !== want.area) begin
               $error("area exp %0d got %0d", want.area, rsp_data.area);
               fail_count++;
            end
         end
      end
   end

   // The result side stalls in random bursts until the quiet tail of the run.
   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            burst = int'($urandom_range(1, 18));
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type lines_of(int v0, int v1, int v2, int v3, int v4,
                                        int v5, int v6, int v7, int v8);
      req_type q;
      q.line1_a = COEFF_WIDTH'(v0); q.line1_b = COEFF_WIDTH'(v1);
      q.line1_c = COEFF_WIDTH'(v2);
      q.line2_a = COEFF_WIDTH'(v3); q.line2_b = COEFF_WIDTH'(v4);
      q.line2_c = COEFF_WIDTH'(v5);
      q.line3_a = COEFF_WIDTH'(v6); q.line3_b = COEFF_WIDTH'(v7);
      q.line3_c = COEFF_WIDTH'(v8);
      return q;
   endfunction

   task automatic test_directed();
      send_lines(lines_of(1, 0, 0, 0, 1, 0, 1, 1, 4));
      send_lines(lines_of(1, 2, 3, 2, 4, 5, 1, -1, 0));
      send_lines(lines_of(1, 1, 0, 1, -1, 3, 2, 2, 7));
      send_lines(lines_of(1, 0, 1, 0, 1, 1, 2, 0, 5));
      send_lines(lines_of(0, 0, 3, 1, 1, 1, 1, -1, 1));
      send_lines(lines_of(1, 1, 1, 0, 0, 5, 1, -1, 1));
      send_lines(lines_of(1, 1, 2, 1, 1, 2, 1, -1, 0));
      send_lines(lines_of(2047, 2046, -2048, 2046, 2045, 2047, 1, -1, 2047));
      send_lines(lines_of(-2048, -2047, 2047, -2047, -2046, -2048, 1, 0, -2048));
      send_lines(lines_of(-2048, 2047, -2048, 2047, -2048, 2047, 1, 1, -2048));
      send_lines(lines_of(-1, 0, 0, 0, -1, 0, -1, -1, -1));
      send_lines(lines_of(2047, -2048, 2047, -2048, 2047, -2048, -1, 1, 0));
      send_lines(lines_of(3, 7, -5, -2, 9, 11, 4, -3, 1));
   endtask

   task automatic test_random(int count);
      repeat (count) send_lines(rand_lines());
   endtask

   task automatic test_drain_pause();
      req_valid <= 1'b0;
      while (triangle_queue.size() != 0) @(posedge clock);
      test_random(50);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(800);
      test_drain_pause();
      test_random(550);
      quiet_tail = 1'b1;
      test_random(200);
      req_valid <= 1'b0;
      while (triangle_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("triangle_area_from_three_lines_tb OK");
      end else begin
         $display("triangle_area_from_three_lines_tb NOT OK");
      end
      $finish;
   end
endmodule
